// File: hdl/aar_pkg.sv
// ---------------------------------------------------------------------------
// aar_pkg
// Shared types and constants for the axis-angle to rotation matrix block.
// ---------------------------------------------------------------------------
package aar_pkg;

  localparam int SINCOS_ITER_DEF = 16;
  localparam int OUT_FRAC_DEF    = 14;
  localparam int ATAN_COUNT      = 24;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [47:0] ONE_Q30      = 48'sd1073741824;
  localparam logic signed [47:0] PI_Q30       = 48'sd3373259426;
  localparam logic signed [47:0] HALF_PI_Q30  = 48'sd1686629713;
  localparam logic signed [47:0] CORDIC_K_Q30 = 48'sd652032874;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] angle;
  } in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               axis_zero;
  } out_t;

  // request as classified by the front end
  typedef struct packed {
    in_t         data;
    logic [31:0] sumsq;
    logic        zero;
  } q_ent_t;

  // arctangent table, Q30, truncated toward zero
  function automatic logic signed [47:0] atan_q30(input int idx);
    logic signed [47:0] r;
    case (idx)
      0:       r = 48'sd843314856;
      1:       r = 48'sd497837829;
      2:       r = 48'sd263043836;
      3:       r = 48'sd133525158;
      4:       r = 48'sd67021686;
      5:       r = 48'sd33543515;
      6:       r = 48'sd16775850;
      7:       r = 48'sd8388437;
      8:       r = 48'sd4194282;
      9:       r = 48'sd2097149;
      10:      r = 48'sd1048575;
      11:      r = 48'sd524287;
      12:      r = 48'sd262143;
      13:      r = 48'sd131071;
      14:      r = 48'sd65535;
      15:      r = 48'sd32767;
      16:      r = 48'sd16383;
      17:      r = 48'sd8191;
      18:      r = 48'sd4095;
      19:      r = 48'sd2047;
      20:      r = 48'sd1023;
      21:      r = 48'sd511;
      22:      r = 48'sd255;
      23:      r = 48'sd127;
      default: r = 48'sd0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/aar_front.sv
// ---------------------------------------------------------------------------
// aar_front
// Input stage: registers a request with the squared axis components, then
// hands it to the queue with its squared length and zero-axis flag.
// ---------------------------------------------------------------------------
module aar_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  aar_pkg::in_t   in_data_i,
  output logic           push_o,
  input  logic           q_full_i,
  output aar_pkg::q_ent_t ent_o
);
  import aar_pkg::*;

  logic               f_v_q, f_v_d;
  in_t                data_q;
  logic [30:0]        sx_q, sy_q, sz_q;
  logic signed [31:0] px, py, pz;
  logic               accept;
  logic [31:0]        sum;

  assign in_stall_o = f_v_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = f_v_q && !q_full_i;

  assign px = in_data_i.axis_x * in_data_i.axis_x;
  assign py = in_data_i.axis_y * in_data_i.axis_y;
  assign pz = in_data_i.axis_z * in_data_i.axis_z;

  assign sum = {1'b0, sx_q} + {1'b0, sy_q} + {1'b0, sz_q};

  assign ent_o.data  = data_q;
  assign ent_o.sumsq = sum;
  assign ent_o.zero  = (sum == 32'd0);

  always_comb begin
    f_v_d = f_v_q;
    if (accept) begin
      f_v_d = 1'b1;
    end else if (push_o) begin
      f_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else begin
      f_v_q <= f_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
      sx_q   <= px[30:0];
      sy_q   <= py[30:0];
      sz_q   <= pz[30:0];
    end
  end

endmodule

// File: hdl/aar_queue.sv
// ---------------------------------------------------------------------------
// aar_queue
// Short FIFO between the front end and the arithmetic pipeline.
// ---------------------------------------------------------------------------
module aar_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  aar_pkg::q_ent_t ent_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output aar_pkg::q_ent_t ent_o
);
  import aar_pkg::*;

  q_ent_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign ent_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = QPTR_W'((32'(wp_q) + 1) % QUEUE_DEPTH);
    end
    if (pop_i) begin
      rp_d = QPTR_W'((32'(rp_q) + 1) % QUEUE_DEPTH);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= ent_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count over depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");

endmodule

// File: hdl/aar_back.sv
// ---------------------------------------------------------------------------
// aar_back
// Arithmetic pipeline: square root and CORDIC side by side, three radix-2
// dividers, the Rodrigues products, rounding and saturation, output register.
// ---------------------------------------------------------------------------
module aar_back #(
  parameter int SINCOS_ITERATIONS = aar_pkg::SINCOS_ITER_DEF,
  parameter int OUT_FRAC_BITS     = aar_pkg::OUT_FRAC_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  aar_pkg::q_ent_t q_ent_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output aar_pkg::out_t   out_data_o
);
  import aar_pkg::*;

  localparam int NIT = (SINCOS_ITERATIONS < ATAN_COUNT) ? SINCOS_ITERATIONS : ATAN_COUNT;
  localparam int SQ_N = 32;
  localparam int DV_N = 31;
  localparam int SH = 30 - OUT_FRAC_BITS;
  localparam int LIM = (OUT_FRAC_BITS >= 15) ? 32767 : (1 << OUT_FRAC_BITS);
  localparam logic signed [40:0] RND_HALF = (SH == 0) ? 41'sd0 : (41'sd1 <<< (SH - 1));
  localparam logic signed [40:0] LIM41 = 41'(LIM);
  localparam logic [15:0] LIM16 = 16'(LIM);

  typedef struct packed {
    logic signed [15:0] ax, ay, az;
    logic               flip;
    logic               zero;
    logic [63:0]        rem;
    logic [63:0]        res;
    logic signed [47:0] cx, cy, cz;
  } sq_t;

  typedef struct packed {
    logic [2:0]         neg;
    logic               zero;
    logic [31:0]        len;
    logic [2:0][61:0]   num;
    logic [2:0][31:0]   rem;
    logic [2:0][30:0]   quo;
    logic signed [33:0] v;
    logic signed [33:0] sn;
  } dv_t;

  typedef struct packed {
    logic               zero;
    logic signed [5:0][33:0] w;
    logic signed [2:0][33:0] q;
    logic signed [33:0] v;
  } m1_t;

  typedef struct packed {
    logic               zero;
    logic signed [5:0][33:0] p;
    logic signed [2:0][33:0] q;
  } m2_t;

  function automatic logic signed [33:0] rnd30(input logic signed [71:0] w);
    logic signed [71:0] t;
    t = (w + 72'sd536870912) >>> 30;
    return t[33:0];
  endfunction

  function automatic logic [15:0] fin(input logic signed [39:0] e);
    logic signed [40:0] r;
    r = (41'(e) + RND_HALF) >>> SH;
    if (r > LIM41) begin
      r = LIM41;
    end else if (r < -LIM41) begin
      r = -LIM41;
    end
    return r[15:0];
  endfunction

  logic              en;
  logic              out_v_q;
  out_t              out_q;

  logic [SQ_N:0]     sq_v_q;
  sq_t               sq_q [SQ_N+1];
  logic [DV_N:0]     dv_v_q;
  dv_t               dv_q [DV_N+1];
  logic              m1_v_q, m2_v_q, fn_v_q;
  m1_t               m1_q;
  m2_t               m2_q;
  out_t              fn_q;

  assign en          = !out_v_q || !out_stall_i;
  assign pop_o       = en && q_valid_i;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // entry: radicand, angle range reduction, CORDIC start
  sq_t s0;
  logic signed [47:0] z0;
  always_comb begin
    z0      = {{15{q_ent_i.data.angle[15]}}, q_ent_i.data.angle, 17'b0};
    s0.ax   = q_ent_i.data.axis_x;
    s0.ay   = q_ent_i.data.axis_y;
    s0.az   = q_ent_i.data.axis_z;
    s0.zero = q_ent_i.zero;
    s0.rem  = {q_ent_i.sumsq, 32'b0};
    s0.res  = '0;
    s0.cx   = CORDIC_K_Q30;
    s0.cy   = '0;
    s0.flip = 1'b0;
    s0.cz   = z0;
    if (z0 > HALF_PI_Q30) begin
      s0.cz   = z0 - PI_Q30;
      s0.flip = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      s0.cz   = z0 + PI_Q30;
      s0.flip = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0] <= s0;
    end
  end

  // one root digit per stage; in the first NIT stages also one CORDIC rotation
  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    sq_t         nxt;
    logic [63:0] trial;
    always_comb begin
      nxt   = sq_q[k];
      trial = sq_q[k].res + BIT;
      if (sq_q[k].rem >= trial) begin
        nxt.rem = sq_q[k].rem - trial;
        nxt.res = (sq_q[k].res >> 1) + BIT;
      end else begin
        nxt.res = sq_q[k].res >> 1;
      end
      if (k < NIT) begin
        if (sq_q[k].cz >= 0) begin
          nxt.cx = sq_q[k].cx - (sq_q[k].cy >>> k);
          nxt.cy = sq_q[k].cy + (sq_q[k].cx >>> k);
          nxt.cz = sq_q[k].cz - atan_q30(k);
        end else begin
          nxt.cx = sq_q[k].cx + (sq_q[k].cy >>> k);
          nxt.cy = sq_q[k].cy - (sq_q[k].cx >>> k);
          nxt.cz = sq_q[k].cz + atan_q30(k);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[k+1] <= nxt;
      end
    end
  end

  // divider setup: rounded numerators, sine and one minus cosine
  dv_t d0;
  logic [2:0][15:0] mag;
  logic signed [2:0][16:0] a17;
  logic signed [47:0] cs, sn;
  always_comb begin
    a17[0] = 17'(sq_q[SQ_N].ax);
    a17[1] = 17'(sq_q[SQ_N].ay);
    a17[2] = 17'(sq_q[SQ_N].az);
    d0      = '0;
    d0.zero = sq_q[SQ_N].zero;
    d0.len  = sq_q[SQ_N].res[31:0];
    for (int i = 0; i < 3; i++) begin
      mag[i]    = a17[i][16] ? 16'(-a17[i]) : a17[i][15:0];
      d0.neg[i] = a17[i][16];
      d0.num[i] = {mag[i], 46'b0} + 62'(d0.len[31:1]);
      d0.rem[i] = {1'b0, d0.num[i][61:31]};
    end
    cs   = sq_q[SQ_N].flip ? -sq_q[SQ_N].cx : sq_q[SQ_N].cx;
    sn   = sq_q[SQ_N].flip ? -sq_q[SQ_N].cy : sq_q[SQ_N].cy;
    d0.v  = 34'(ONE_Q30 - cs);
    d0.sn = sn[33:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0] <= d0;
    end
  end

  // restoring division, one quotient bit per stage for each component
  for (genvar j = 0; j < DV_N; j++) begin : g_dv
    dv_t         nxt;
    logic [32:0] trial;
    always_comb begin
      nxt   = dv_q[j];
      trial = '0;
      for (int i = 0; i < 3; i++) begin
        trial = {dv_q[j].rem[i], dv_q[j].num[i][DV_N-1-j]};
        if (trial >= {1'b0, dv_q[j].len}) begin
          nxt.rem[i] = 32'(trial - {1'b0, dv_q[j].len});
          nxt.quo[i] = {dv_q[j].quo[i][29:0], 1'b1};
        end else begin
          nxt.rem[i] = trial[31:0];
          nxt.quo[i] = {dv_q[j].quo[i][29:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[j+1] <= nxt;
      end
    end
  end

  // axis products and sine terms
  m1_t m1_d;
  logic signed [2:0][31:0] u;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i] = dv_q[DV_N].neg[i] ? -32'(dv_q[DV_N].quo[i]) : 32'(dv_q[DV_N].quo[i]);
      m1_d.q[i] = rnd30(72'($signed(u[i])) * 72'(dv_q[DV_N].sn));
    end
    m1_d.w[0] = rnd30(72'($signed(u[0])) * 72'($signed(u[0])));
    m1_d.w[1] = rnd30(72'($signed(u[1])) * 72'($signed(u[1])));
    m1_d.w[2] = rnd30(72'($signed(u[2])) * 72'($signed(u[2])));
    m1_d.w[3] = rnd30(72'($signed(u[0])) * 72'($signed(u[1])));
    m1_d.w[4] = rnd30(72'($signed(u[1])) * 72'($signed(u[2])));
    m1_d.w[5] = rnd30(72'($signed(u[2])) * 72'($signed(u[0])));
    m1_d.v    = dv_q[DV_N].v;
    m1_d.zero = dv_q[DV_N].zero;
  end

  // scale by one minus cosine
  m2_t m2_d;
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      m2_d.p[i] = rnd30(72'($signed(m1_q.w[i])) * 72'(m1_q.v));
    end
    m2_d.q    = m1_q.q;
    m2_d.zero = m1_q.zero;
  end

  // matrix entries; p order is xx, yy, zz, xy, yz, zx
  out_t fn_d;
  logic signed [39:0] one40;
  logic signed [8:0][39:0] e;
  always_comb begin
    one40 = 40'(ONE_Q30);
    e[0] = one40 - 40'($signed(m2_q.p[2])) - 40'($signed(m2_q.p[1]));
    e[1] = 40'($signed(m2_q.p[3])) - 40'($signed(m2_q.q[2]));
    e[2] = 40'($signed(m2_q.q[1])) + 40'($signed(m2_q.p[5]));
    e[3] = 40'($signed(m2_q.q[2])) + 40'($signed(m2_q.p[3]));
    e[4] = one40 - 40'($signed(m2_q.p[2])) - 40'($signed(m2_q.p[0]));
    e[5] = 40'($signed(m2_q.p[4])) - 40'($signed(m2_q.q[0]));
    e[6] = 40'($signed(m2_q.p[5])) - 40'($signed(m2_q.q[1]));
    e[7] = 40'($signed(m2_q.q[0])) + 40'($signed(m2_q.p[4]));
    e[8] = one40 - 40'($signed(m2_q.p[1])) - 40'($signed(m2_q.p[0]));
    if (m2_q.zero) begin
      fn_d.m00 = LIM16; fn_d.m01 = '0;    fn_d.m02 = '0;
      fn_d.m10 = '0;    fn_d.m11 = LIM16; fn_d.m12 = '0;
      fn_d.m20 = '0;    fn_d.m21 = '0;    fn_d.m22 = LIM16;
    end else begin
      fn_d.m00 = fin(e[0]); fn_d.m01 = fin(e[1]); fn_d.m02 = fin(e[2]);
      fn_d.m10 = fin(e[3]); fn_d.m11 = fin(e[4]); fn_d.m12 = fin(e[5]);
      fn_d.m20 = fin(e[6]); fn_d.m21 = fin(e[7]); fn_d.m22 = fin(e[8]);
    end
    fn_d.axis_zero = m2_q.zero;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q <= m1_d;
      m2_q <= m2_d;
      fn_q <= fn_d;
      out_q <= fn_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q  <= '0;
      dv_v_q  <= '0;
      m1_v_q  <= 1'b0;
      m2_v_q  <= 1'b0;
      fn_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      sq_v_q  <= {sq_v_q[SQ_N-1:0], pop_o};
      dv_v_q  <= {dv_v_q[DV_N-1:0], sq_v_q[SQ_N]};
      m1_v_q  <= dv_v_q[DV_N];
      m2_v_q  <= m1_v_q;
      fn_v_q  <= m2_v_q;
      out_v_q <= fn_v_q;
    end
  end

  a_zero_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.axis_zero |-> out_q.m00 == LIM16 && out_q.m01 == '0 &&
      out_q.m22 == LIM16) else $error("zero axis did not give identity");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(fn_v_q) && $stable(sq_v_q)) else $error("pipeline moved while held");

endmodule

// File: hdl/axis_angle_to_rotation_matrix.sv
// ---------------------------------------------------------------------------
// axis_angle_to_rotation_matrix
// Axis (Q4.12) and angle (Q3.13 radians) to a 3x3 rotation matrix by
// Rodrigues' formula.
// ---------------------------------------------------------------------------
// Takes one request per cycle while in_stall_o is low and returns one matrix
// per request, in order. A request passes the input register, the queue, 32
// square-root stages with the CORDIC alongside, 31 divider stages, two
// multiply stages, rounding and the output register; latency is set by the
// digit-per-stage square root and divider. A zero-length axis gives the
// identity with axis_zero set. A stall on the output holds the whole
// pipeline; the four-entry queue keeps the input side taking requests
// meanwhile.
module axis_angle_to_rotation_matrix #(
  parameter int SINCOS_ITERATIONS = aar_pkg::SINCOS_ITER_DEF,
  parameter int OUT_FRAC_BITS     = aar_pkg::OUT_FRAC_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  aar_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output aar_pkg::out_t out_data_o
);
  import aar_pkg::*;

  logic   push, full, pop, q_valid;
  q_ent_t ent_in, ent_out;

  aar_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .q_full_i   (full),
    .ent_o      (ent_in)
  );

  aar_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (ent_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .ent_o   (ent_out)
  );

  aar_back #(
    .SINCOS_ITERATIONS (SINCOS_ITERATIONS),
    .OUT_FRAC_BITS     (OUT_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ent_i     (ent_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
